// ----- rtl/snd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Split-normal density package
// Shared widths, Q.32 constants, status codes, side-band types and the
// elaboration-time helpers that build the exp2 factor table.
// ----------------------------------------------------------------------------
package snd_pkg;

	localparam int DATA_WIDTH_DEF = 32;
	localparam int FRAC_BITS_DEF  = 16;
	localparam int LOG_LAT        = 34;
	localparam int EXP_LAT        = 34;

	typedef logic signed [63:0] q32_t;
	typedef logic [63:0]        u64_t;

	localparam u64_t LN2_Q32        = 64'd2977044472;
	localparam u64_t LOG2E_FRAC_Q32 = 64'd1901360723;
	localparam u64_t PI_Q32         = 64'd13493037705;

	localparam q32_t ONE_Q32  = 64'sd1 <<< 32;
	localparam q32_t Q_CAP    = 64'sd30 <<< 32;
	localparam q32_t ARG_BIAS = 64'sd32 <<< 32;
	localparam q32_t Q_CAPPED = 64'sd1 <<< 62;

	localparam logic [1:0] ST_OK  = 2'd0;
	localparam logic [1:0] ST_BAD = 2'd1;
	localparam logic [1:0] ST_SAT = 2'd2;

	typedef struct packed {
		logic bad;
		logic above;
		logic dnz;
	} sb1_t;

	typedef struct packed {
		q32_t k;
		logic capped;
		logic dnz;
		logic bad;
	} sb2_t;

	typedef struct packed {
		u64_t lmag;
		logic lneg;
		logic capped;
		logic bad;
	} sb3_t;

	function automatic u64_t isqrt64(input u64_t v);
		u64_t x;
		u64_t r;
		u64_t b;
		x = v;
		r = '0;
		for (int j = 31; j >= 0; j--) begin
			b = 64'd1 << (2 * j);
			if (x >= r + b) begin
				x = x - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
		end
		return r;
	endfunction

	// 2^(2^-i) in Q1.31
	function automatic logic [31:0] exp_tab(input int i);
		u64_t t;
		t = isqrt64(64'd1 << 63);
		for (int j = 2; j <= i; j++) begin
			t = isqrt64(t << 31);
		end
		return t[31:0];
	endfunction

	function automatic q32_t lg2_const(input u64_t v);
		int n;
		u64_t y;
		logic [31:0] fr;
		n = 0;
		fr = '0;
		for (int j = 0; j < 64; j++) begin
			if (v[j]) n = j;
		end
		if (n > 31) y = v >> (n - 31);
		else y = v << (31 - n);
		for (int i = 0; i < 32; i++) begin
			y = (y * y) >> 31;
			if (y[32]) begin
				y = y >> 1;
				fr[31 - i] = 1'b1;
			end
		end
		return (q32_t'(n) <<< 32) + q32_t'({32'd0, fr});
	endfunction

	// log2(sqrt(2/pi)) in Q.32
	localparam q32_t LOG_C = ((64'sd33 <<< 32) - lg2_const(PI_Q32)) / 2;

endpackage

// ----- rtl/snd_delay.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Side-band delay line
// Carries a valid bit and a payload alongside a fixed-latency unit.
// ----------------------------------------------------------------------------
module snd_delay #(
	parameter int W     = 1,
	parameter int DEPTH = 1
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         en,
	input  logic         v_in,
	input  logic [W-1:0] d_in,
	output logic         v_out,
	output logic [W-1:0] d_out
);

	logic         v_s [0:DEPTH-1];
	logic [W-1:0] d_s [0:DEPTH-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DEPTH; i++) v_s[i] <= 1'b0;
		end else if (en) begin
			v_s[0] <= v_in;
			for (int i = 1; i < DEPTH; i++) v_s[i] <= v_s[i-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_s[0] <= d_in;
			for (int i = 1; i < DEPTH; i++) d_s[i] <= d_s[i-1];
		end
	end

	assign v_out = v_s[DEPTH-1];
	assign d_out = d_s[DEPTH-1];

endmodule

// ----- rtl/snd_log2.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pipelined log2
// Two normalize stages, then one squaring stage per fraction bit (Q.32 out).
// ----------------------------------------------------------------------------
module snd_log2 (
	input  logic               clk,
	input  logic               en,
	input  logic [63:0]        v,
	output snd_pkg::q32_t      lg
);

	logic [63:0] w_a;
	logic [5:0]  nz_a;
	logic [63:0] w_b;
	logic [5:0]  nz_b;
	logic [63:0] w_s1;
	logic [5:0]  nz_s1;

	logic [31:0] y_s  [0:31];
	logic [5:0]  n_s  [0:32];
	logic [31:0] fr_s [0:32];

	always_comb begin
		w_a = v;
		nz_a = '0;
		if (w_a[63:32] == '0) begin
			w_a = w_a << 32;
			nz_a = nz_a + 6'd32;
		end
		if (w_a[63:48] == '0) begin
			w_a = w_a << 16;
			nz_a = nz_a + 6'd16;
		end
		if (w_a[63:56] == '0) begin
			w_a = w_a << 8;
			nz_a = nz_a + 6'd8;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			w_s1  <= w_a;
			nz_s1 <= nz_a;
		end
	end

	always_comb begin
		w_b = w_s1;
		nz_b = nz_s1;
		if (w_b[63:60] == '0) begin
			w_b = w_b << 4;
			nz_b = nz_b + 6'd4;
		end
		if (w_b[63:62] == '0) begin
			w_b = w_b << 2;
			nz_b = nz_b + 6'd2;
		end
		if (!w_b[63]) begin
			w_b = w_b << 1;
			nz_b = nz_b + 6'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			y_s[0]  <= w_b[63:32];
			n_s[0]  <= ~nz_b;
			fr_s[0] <= '0;
		end
	end

	for (genvar j = 0; j < 32; j++) begin : g_sq
		localparam logic [31:0] BIT = 32'd1 << (31 - j);
		logic [63:0] prod;
		logic [32:0] t;

		assign prod = {32'd0, y_s[j]} * {32'd0, y_s[j]};
		assign t    = prod[63:31];

		always_ff @(posedge clk) begin
			if (en) begin
				n_s[j+1]  <= n_s[j];
				fr_s[j+1] <= t[32] ? (fr_s[j] | BIT) : fr_s[j];
			end
		end

		if (j < 31) begin : g_y
			always_ff @(posedge clk) begin
				if (en) y_s[j+1] <= t[32] ? t[32:1] : t[31:0];
			end
		end
	end

	assign lg = snd_pkg::q32_t'({26'd0, n_s[32], fr_s[32]});

endmodule

// ----- rtl/snd_exp2.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pipelined exp2
// Rounded integer 2^(a/2^32): one factor stage per fraction bit, then a
// final scale and round stage; saturates to all ones.
// ----------------------------------------------------------------------------
module snd_exp2 (
	input  logic               clk,
	input  logic               en,
	input  snd_pkg::q32_t      a,
	output logic [63:0]        r
);

	logic signed [31:0] k_s [0:32];
	logic [31:0]        f_s [0:31];
	logic [31:0]        y_s [0:32];

	logic [4:0]  shl;
	logic [5:0]  shr;
	logic [63:0] r_c;
	logic [63:0] r_q;

	always_ff @(posedge clk) begin
		if (en) begin
			k_s[0] <= a[63:32];
			f_s[0] <= a[31:0];
			y_s[0] <= 32'h8000_0000;
		end
	end

	for (genvar i = 1; i <= 32; i++) begin : g_mul
		localparam logic [31:0] TAB = snd_pkg::exp_tab(i);
		logic [63:0] prod;

		assign prod = {32'd0, y_s[i-1]} * {32'd0, TAB};

		always_ff @(posedge clk) begin
			if (en) begin
				y_s[i] <= f_s[i-1][32-i] ? prod[62:31] : y_s[i-1];
				k_s[i] <= k_s[i-1];
			end
		end

		if (i < 32) begin : g_f
			always_ff @(posedge clk) begin
				if (en) f_s[i] <= f_s[i-1];
			end
		end
	end

	always_comb begin
		shl = 5'(k_s[32] - 32'sd31);
		shr = 6'(32'sd31 - k_s[32]);
		if (k_s[32] >= 32'sd62) begin
			r_c = '1;
		end else if (k_s[32] >= 32'sd31) begin
			r_c = {32'd0, y_s[32]} << shl;
		end else if (k_s[32] < -32'sd32) begin
			r_c = '0;
		end else begin
			r_c = ({32'd0, y_s[32]} + (64'd1 << (shr - 6'd1))) >> shr;
		end
	end

	always_ff @(posedge clk) begin
		if (en) r_q <= r_c;
	end

	assign r = r_q;

endmodule

// ----- rtl/split_normal_density_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Split-normal density unit
// Evaluates the split-normal density, or its natural log, per request.
// ----------------------------------------------------------------------------
// Takes one request per cycle unless a held result stalls the pipeline and
// returns its result through three fixed-latency units in series (a 34-stage
// log2 bank, then two 34-stage exp2 units, one squaring or factor multiply
// per fraction bit). A stall on the result side freezes the whole pipeline,
// so in_stall follows out_stall while a result is held. log_output selects
// the log form. Write it only while no request is in flight; not enforced.
module split_normal_density_unit #(
	parameter int DATA_WIDTH = snd_pkg::DATA_WIDTH_DEF,
	parameter int FRAC_BITS  = snd_pkg::FRAC_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic signed [DATA_WIDTH-1:0] quantile,
	input  logic signed [DATA_WIDTH-1:0] location,
	input  logic signed [DATA_WIDTH-1:0] scale,
	input  logic signed [DATA_WIDTH-1:0] skew,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic signed [DATA_WIDTH-1:0] value,
	output logic [1:0]                   status,
	input  logic                         cfg_we,
	input  logic                         cfg_wdata
);

	localparam snd_pkg::q32_t FSH   = snd_pkg::q32_t'(FRAC_BITS) <<< 32;
	localparam snd_pkg::u64_t MAXV  = (64'd1 << (DATA_WIDTH - 1)) - 64'd1;
	localparam snd_pkg::u64_t MAXV1 = 64'd1 << (DATA_WIDTH - 1);
	localparam snd_pkg::u64_t FBONE = 64'd1 << FRAC_BITS;
	localparam int            RSH   = 32 - FRAC_BITS;

	logic adv;
	logic log_output_q;

	// stage 1
	logic                         v_s1;
	logic signed [DATA_WIDTH-1:0] y_s1, mu_s1, sg_s1, lm_s1;
	logic signed [DATA_WIDTH:0]   ya, ma, diff;
	snd_pkg::sb1_t                sb1_c;
	snd_pkg::u64_t                d_c;

	// stage 2
	logic          v_s2;
	snd_pkg::sb1_t sb1_s2;
	snd_pkg::u64_t d_s2, sg_s2, lm_s2, lmp_s2;

	// log2 outputs
	snd_pkg::q32_t lsg, llm, llmp, ld;
	logic          v_l;
	snd_pkg::sb1_t sb1_l;

	// stages 4 to 6
	logic          v_s4, v_s5, v_s6;
	snd_pkg::q32_t la_s4, lb_s4, lp_s4, ld_s4;
	snd_pkg::sb1_t sb1_s4;
	snd_pkg::q32_t k_s5, g_s5;
	logic          dnz_s5, bad_s5;
	snd_pkg::q32_t arg_s6;
	snd_pkg::sb2_t sb2_s6;

	// exp2 for q
	logic [63:0]   e1_r;
	logic          v_e1;
	snd_pkg::sb2_t sb2_e1;
	snd_pkg::q32_t q_c;

	// stages 8 to 13
	logic          v_s8, v_s9, v_s10, v_s11, v_s12, v_s13;
	snd_pkg::q32_t q_s8, k_s8;
	logic          cap_s8, bad_s8;
	snd_pkg::u64_t km_s9;
	logic          kneg_s9;
	snd_pkg::q32_t q_s9, k_s9;
	logic          cap_s9, bad_s9;
	snd_pkg::u64_t pkh_s10, pkl_s10, pqh_s10, pql_s10;
	logic          kneg_s10;
	snd_pkg::q32_t q_s10, k_s10;
	logic          cap_s10, bad_s10;
	snd_pkg::u64_t mkm_c;
	snd_pkg::q32_t mk_s11, mq_s11, q_s11, k_s11;
	logic          cap_s11, bad_s11;
	snd_pkg::q32_t l_s12, darg_s12;
	logic          cap_s12, bad_s12;
	snd_pkg::u64_t lmag_s13;
	logic          lneg_s13, cap_s13, bad_s13;
	snd_pkg::q32_t darg_s13;
	snd_pkg::u64_t lrnd_c;
	snd_pkg::sb3_t sb3_c;

	// exp2 for density, final
	logic [63:0]   e2_r;
	logic          v_e2;
	snd_pkg::sb3_t sb3_e2;
	snd_pkg::u64_t m_c, res_c;
	logic [1:0]    st_c;
	logic          sat_c;

	logic                         out_valid_q;
	logic signed [DATA_WIDTH-1:0] value_q;
	logic [1:0]                   status_q;

	assign adv      = !(out_valid_q && out_stall);
	assign in_stall = !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			log_output_q <= 1'b0;
		end else if (cfg_we) begin
			log_output_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s4        <= 1'b0;
			v_s5        <= 1'b0;
			v_s6        <= 1'b0;
			v_s8        <= 1'b0;
			v_s9        <= 1'b0;
			v_s10       <= 1'b0;
			v_s11       <= 1'b0;
			v_s12       <= 1'b0;
			v_s13       <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1        <= in_valid;
			v_s2        <= v_s1;
			v_s4        <= v_l;
			v_s5        <= v_s4;
			v_s6        <= v_s5;
			v_s8        <= v_e1;
			v_s9        <= v_s8;
			v_s10       <= v_s9;
			v_s11       <= v_s10;
			v_s12       <= v_s11;
			v_s13       <= v_s12;
			out_valid_q <= v_e2;
		end
	end

	always_comb begin
		ya = {y_s1[DATA_WIDTH-1], y_s1};
		ma = {mu_s1[DATA_WIDTH-1], mu_s1};
		sb1_c.bad   = (sg_s1 <= 0) || (lm_s1 <= 0);
		sb1_c.above = y_s1 > mu_s1;
		diff = sb1_c.above ? (ya - ma) : (ma - ya);
		d_c = 64'(diff);
		sb1_c.dnz = d_c != '0;
	end

	assign q_c = !sb2_e1.dnz ? '0 :
		(sb2_e1.capped ? snd_pkg::Q_CAPPED : snd_pkg::q32_t'(e1_r));

	assign mkm_c = pkh_s10 + (pkl_s10 >> 32);

	always_ff @(posedge clk) begin
		if (adv) begin
			y_s1  <= quantile;
			mu_s1 <= location;
			sg_s1 <= scale;
			lm_s1 <= skew;

			sb1_s2 <= sb1_c;
			d_s2   <= d_c;
			sg_s2  <= 64'(sg_s1);
			lm_s2  <= 64'(lm_s1);
			lmp_s2 <= 64'(lm_s1) + FBONE;

			la_s4  <= lsg - FSH;
			lb_s4  <= llm - FSH;
			lp_s4  <= llmp - FSH;
			ld_s4  <= ld - FSH;
			sb1_s4 <= sb1_l;

			k_s5   <= snd_pkg::LOG_C - lp_s4 - la_s4;
			g_s5   <= ((ld_s4 - la_s4 - (sb1_s4.above ? lb_s4 : '0)) <<< 1) - snd_pkg::ONE_Q32;
			dnz_s5 <= sb1_s4.dnz;
			bad_s5 <= sb1_s4.bad;

			arg_s6        <= g_s5 + snd_pkg::ARG_BIAS;
			sb2_s6.k      <= k_s5;
			sb2_s6.capped <= dnz_s5 && (g_s5 >= snd_pkg::Q_CAP);
			sb2_s6.dnz    <= dnz_s5;
			sb2_s6.bad    <= bad_s5;

			q_s8   <= q_c;
			k_s8   <= sb2_e1.k;
			cap_s8 <= sb2_e1.capped;
			bad_s8 <= sb2_e1.bad;

			kneg_s9 <= k_s8[63];
			km_s9   <= k_s8[63] ? 64'(-k_s8) : 64'(k_s8);
			q_s9    <= q_s8;
			k_s9    <= k_s8;
			cap_s9  <= cap_s8;
			bad_s9  <= bad_s8;

			pkh_s10  <= {32'd0, km_s9[63:32]} * snd_pkg::LN2_Q32;
			pkl_s10  <= {32'd0, km_s9[31:0]} * snd_pkg::LN2_Q32;
			pqh_s10  <= {32'd0, q_s9[63:32]} * snd_pkg::LOG2E_FRAC_Q32;
			pql_s10  <= {32'd0, q_s9[31:0]} * snd_pkg::LOG2E_FRAC_Q32;
			kneg_s10 <= kneg_s9;
			q_s10    <= q_s9;
			k_s10    <= k_s9;
			cap_s10  <= cap_s9;
			bad_s10  <= bad_s9;

			mk_s11  <= kneg_s10 ? -snd_pkg::q32_t'(mkm_c) : snd_pkg::q32_t'(mkm_c);
			mq_s11  <= snd_pkg::q32_t'(pqh_s10 + (pql_s10 >> 32));
			q_s11   <= q_s10;
			k_s11   <= k_s10;
			cap_s11 <= cap_s10;
			bad_s11 <= bad_s10;

			l_s12    <= mk_s11 - q_s11;
			darg_s12 <= k_s11 - q_s11 - mq_s11 + FSH;
			cap_s12  <= cap_s11;
			bad_s12  <= bad_s11;

			lneg_s13 <= l_s12[63];
			lmag_s13 <= l_s12[63] ? 64'(-l_s12) : 64'(l_s12);
			darg_s13 <= darg_s12;
			cap_s13  <= cap_s12;
			bad_s13  <= bad_s12;

			value_q  <= DATA_WIDTH'(res_c);
			status_q <= st_c;
		end
	end

	snd_log2 u_lg_sg  (.clk(clk), .en(adv), .v(sg_s2),  .lg(lsg));
	snd_log2 u_lg_lm  (.clk(clk), .en(adv), .v(lm_s2),  .lg(llm));
	snd_log2 u_lg_lmp (.clk(clk), .en(adv), .v(lmp_s2), .lg(llmp));
	snd_log2 u_lg_d   (.clk(clk), .en(adv), .v(d_s2),   .lg(ld));

	snd_delay #(.W($bits(snd_pkg::sb1_t)), .DEPTH(snd_pkg::LOG_LAT)) u_dl_lg (
		.clk(clk), .arst_n(arst_n), .en(adv),
		.v_in(v_s2), .d_in(sb1_s2), .v_out(v_l), .d_out(sb1_l)
	);

	snd_exp2 u_ex_q (.clk(clk), .en(adv), .a(arg_s6), .r(e1_r));

	snd_delay #(.W($bits(snd_pkg::sb2_t)), .DEPTH(snd_pkg::EXP_LAT)) u_dl_q (
		.clk(clk), .arst_n(arst_n), .en(adv),
		.v_in(v_s6), .d_in(sb2_s6), .v_out(v_e1), .d_out(sb2_e1)
	);

	// log result rounded half away from zero
	if (RSH > 0) begin : g_rnd
		assign lrnd_c = (lmag_s13 + (64'd1 << (RSH - 1))) >> RSH;
	end else begin : g_nornd
		assign lrnd_c = lmag_s13;
	end

	always_comb begin
		sb3_c.lmag   = lrnd_c;
		sb3_c.lneg   = lneg_s13;
		sb3_c.capped = cap_s13;
		sb3_c.bad    = bad_s13;
	end

	snd_exp2 u_ex_d (.clk(clk), .en(adv), .a(darg_s13), .r(e2_r));

	snd_delay #(.W($bits(snd_pkg::sb3_t)), .DEPTH(snd_pkg::EXP_LAT)) u_dl_d (
		.clk(clk), .arst_n(arst_n), .en(adv),
		.v_in(v_s13), .d_in(sb3_c), .v_out(v_e2), .d_out(sb3_e2)
	);

	always_comb begin
		m_c   = sb3_e2.lmag;
		sat_c = 1'b0;
		if (log_output_q) begin
			if (sb3_e2.lneg) begin
				if (m_c > MAXV1) begin
					m_c = MAXV1;
					sat_c = 1'b1;
				end
				res_c = 64'd0 - m_c;
			end else begin
				if (m_c > MAXV) begin
					m_c = MAXV;
					sat_c = 1'b1;
				end
				res_c = m_c;
			end
			st_c = (sat_c || sb3_e2.capped) ? snd_pkg::ST_SAT : snd_pkg::ST_OK;
		end else begin
			if (e2_r > MAXV) begin
				res_c = MAXV;
				st_c  = snd_pkg::ST_SAT;
			end else begin
				res_c = e2_r;
				st_c  = snd_pkg::ST_OK;
			end
		end
		if (sb3_e2.bad) begin
			res_c = '0;
			st_c  = snd_pkg::ST_BAD;
		end
	end

	assign out_valid = out_valid_q;
	assign value     = value_q;
	assign status    = status_q;

`ifndef ASSERT_OFF
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == snd_pkg::ST_BAD |-> value == '0)
		else $error("bad-parameter result with nonzero value");

	a_density_pos: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !log_output_q |-> !value[DATA_WIDTH-1])
		else $error("negative density");

	a_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && !adv |=> v_s1 && $stable(y_s1) && $stable(sg_s1))
		else $error("pipeline moved while frozen");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status == snd_pkg::ST_OK || status == snd_pkg::ST_BAD ||
			status == snd_pkg::ST_SAT)
		else $error("undefined status code");
`endif

endmodule
